>>> design/tvbd_pkg.sv
// ---------------------------------------------------------------------------
// tvbd_pkg: shared types and constants
// Types, register codes, cipher constants and helper functions used by the
// TEA-variant block decryptor.
// ---------------------------------------------------------------------------
`default_nettype none

package tvbd_pkg;

  // Sum schedule of the cipher.
  localparam logic [31:0] SUM_START = 32'hC6EF3720;
  localparam logic [31:0] SUM_STEP  = 32'h61C88647;

  // Tail strings, indexed by the descending tail index; the last entry pads.
  localparam logic [7:0] TAIL_STD [8] = '{8'h58, 8'h74, 8'h45, 8'h61,
                                          8'h4E, 8'h70, 8'h4B, 8'h00};
  localparam logic [7:0] TAIL_VAR [8] = '{8'h4E, 8'h70, 8'h4B, 8'h21,
                                          8'h54, 8'h65, 8'h41, 8'h00};

  // Configuration register codes (word index on the APB port).
  typedef enum logic [2:0] {
    REG_KEY0        = 3'd0,
    REG_KEY1        = 3'd1,
    REG_KEY2        = 3'd2,
    REG_KEY3        = 3'd3,
    REG_USE_VARIANT = 3'd4,
    REG_TAIL_ENABLE = 3'd5
  } reg_idx_t;

  // Configuration seen by the datapath.
  typedef struct packed {
    logic [3:0][31:0] key;
    logic [3:0][7:0]  kmod;
    logic             variant;
    logic             tail_en;
  } tvbd_cfg_t;

  // Payload carried down the pipeline.
  typedef struct packed {
    logic        full;
    logic [3:0]  count;
    logic [31:0] x;
    logic [31:0] y;
  } tvbd_word_t;

  // One pipeline slot: valid bit plus payload.
  typedef struct packed {
    logic       valid;
    tvbd_word_t w;
  } tvbd_pipe_t;

  // Running sum at the start of round r.
  function automatic logic [31:0] sum_at(input int unsigned r);
    logic [31:0] rr;
    rr = 32'(r);
    return SUM_START + rr * SUM_STEP;
  endfunction

  // A 32-bit value modulo 255: since 256 is 1 mod 255, fold the bytes.
  function automatic logic [7:0] mod255(input logic [31:0] v);
    logic [9:0] s;
    logic [8:0] t;
    s = {2'b00, v[7:0]} + {2'b00, v[15:8]} + {2'b00, v[23:16]} + {2'b00, v[31:24]};
    t = {7'b0, s[9:8]} + {1'b0, s[7:0]};
    if (t >= 9'd255) begin
      t = t - 9'd255;
    end
    return t[7:0];
  endfunction

endpackage

`default_nettype wire

>>> design/tvbd_in_if.sv
// ---------------------------------------------------------------------------
// tvbd_in_if: request channel into the decryptor
// Carries one ciphertext block and its valid byte count per request.
// ---------------------------------------------------------------------------
`default_nettype none

interface tvbd_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] block_data;
  logic [3:0]  byte_count;

  modport source (output valid, output block_data, output byte_count, input ready);
  modport sink   (input valid, input block_data, input byte_count, output ready);
endinterface

`default_nettype wire

>>> design/tvbd_out_if.sv
// ---------------------------------------------------------------------------
// tvbd_out_if: result channel out of the decryptor
// Carries one plaintext block and its valid byte count per request.
// ---------------------------------------------------------------------------
`default_nettype none

interface tvbd_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] plain_data;
  logic [3:0]  plain_count;

  modport source (output valid, output plain_data, output plain_count, input ready);
  modport sink   (input valid, input plain_data, input plain_count, output ready);
endinterface

`default_nettype wire

>>> design/tvbd_cfg.sv
// ---------------------------------------------------------------------------
// tvbd_cfg: APB configuration registers
// Holds the key words, the mode bits and the key words reduced mod 255.
// ---------------------------------------------------------------------------
`default_nettype none

module tvbd_cfg (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [4:0]          paddr,
  input  wire logic [31:0]         pwdata,
  output      logic [31:0]         prdata,
  output      logic                pready,
  output      tvbd_pkg::tvbd_cfg_t cfg
);

  logic [3:0][31:0]   key_r;
  logic [3:0][7:0]    kmod_r;
  logic               variant_r;
  logic               tail_en_r;
  logic               wr_en;
  tvbd_pkg::reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;
  assign idx    = tvbd_pkg::reg_idx_t'(paddr[4:2]);

  // Register writes; the mod-255 key reduction is taken at write time.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_r     <= '0;
      kmod_r    <= '0;
      variant_r <= 1'b0;
      tail_en_r <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        tvbd_pkg::REG_KEY0, tvbd_pkg::REG_KEY1,
        tvbd_pkg::REG_KEY2, tvbd_pkg::REG_KEY3: begin
          key_r[idx[1:0]]  <= pwdata;
          kmod_r[idx[1:0]] <= tvbd_pkg::mod255(pwdata);
        end
        tvbd_pkg::REG_USE_VARIANT: variant_r <= pwdata[0];
        tvbd_pkg::REG_TAIL_ENABLE: tail_en_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read-back mux.
  always_comb begin
    case (idx)
      tvbd_pkg::REG_KEY0, tvbd_pkg::REG_KEY1,
      tvbd_pkg::REG_KEY2, tvbd_pkg::REG_KEY3: prdata = key_r[idx[1:0]];
      tvbd_pkg::REG_USE_VARIANT:             prdata = {31'b0, variant_r};
      tvbd_pkg::REG_TAIL_ENABLE:             prdata = {31'b0, tail_en_r};
      default:                               prdata = '0;
    endcase
  end

  assign cfg.key     = key_r;
  assign cfg.kmod    = kmod_r;
  assign cfg.variant = variant_r;
  assign cfg.tail_en = tail_en_r;

endmodule

`default_nettype wire

>>> design/tvbd_tail.sv
// ---------------------------------------------------------------------------
// tvbd_tail: input capture stage
// Registers each request, splits full blocks into words and finishes
// partial tail items with the tail XOR so they can ride the pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

module tvbd_tail (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire logic                 in_valid,
  input  wire logic [63:0]          block_data,
  input  wire logic [3:0]           byte_count,
  input  wire tvbd_pkg::tvbd_cfg_t  cfg,
  output      tvbd_pkg::tvbd_pipe_t pipe_out
);

  logic                 valid_r;
  tvbd_pkg::tvbd_word_t word_r;
  tvbd_pkg::tvbd_word_t word_nxt;
  logic [63:0]          tail_res;
  logic [2:0]           idx;
  logic [7:0]           pad;
  logic                 full;

  assign full = byte_count[3];

  // Tail lanes: byte p uses the descending index count-1-p.
  always_comb begin
    tail_res = '0;
    idx      = '0;
    pad      = '0;
    for (int p = 0; p < 8; p++) begin
      idx = 3'(byte_count - 4'(p + 1));
      pad = cfg.variant ? tvbd_pkg::TAIL_VAR[idx] : tvbd_pkg::TAIL_STD[idx];
      pad = pad ^ cfg.kmod[idx[1:0]];
      if (!cfg.tail_en) begin
        pad = '0;
      end
      if (4'(p) < byte_count) begin
        tail_res[8*p +: 8] = block_data[8*p +: 8] ^ pad;
      end
    end
  end

  // Full blocks go on as words; tails are already finished.
  always_comb begin
    word_nxt.full  = full;
    word_nxt.count = byte_count;
    word_nxt.x     = full ? block_data[31:0]  : tail_res[31:0];
    word_nxt.y     = full ? block_data[63:32] : tail_res[63:32];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign pipe_out.valid = valid_r;
  assign pipe_out.w     = word_r;

endmodule

`default_nettype wire

>>> design/tvbd_stage.sv
// ---------------------------------------------------------------------------
// tvbd_stage: one registered half round
// Updates one word of a full block from the other word; the sum and key
// selection are fixed per stage. Tail items pass through unchanged.
// ---------------------------------------------------------------------------
`default_nettype none

module tvbd_stage #(
  parameter logic [31:0] SUM_STD = 32'h0,
  parameter logic [31:0] SUM_VAR = 32'h0,
  parameter bit          UPD_X   = 1'b0
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 en,
  input  wire tvbd_pkg::tvbd_cfg_t  cfg,
  input  wire tvbd_pkg::tvbd_pipe_t pipe_in,
  output      tvbd_pkg::tvbd_pipe_t pipe_out
);

  // Standard mixing key index; the y update flips the low bit.
  localparam logic [1:0] KIDX = SUM_STD[3:2] ^ {1'b0, ~UPD_X};
  // Variant mixing keys: y update uses key 3 and 2, x update key 1 and 0.
  localparam logic [1:0] KA   = UPD_X ? 2'd1 : 2'd3;
  localparam logic [1:0] KB   = UPD_X ? 2'd0 : 2'd2;

  logic                 valid_r;
  tvbd_pkg::tvbd_word_t word_r;
  tvbd_pkg::tvbd_word_t word_nxt;
  logic [31:0]          src;
  logic [31:0]          dst;
  logic [31:0]          mix_std;
  logic [31:0]          mix_var;
  logic [31:0]          dst_nxt;

  assign src = UPD_X ? pipe_in.w.y : pipe_in.w.x;
  assign dst = UPD_X ? pipe_in.w.x : pipe_in.w.y;

  // Both round functions; the mode bit picks one before the subtract.
  assign mix_std = ((SUM_STD ^ src) + (src ^ cfg.key[KIDX])) ^
                   (((src << 2) ^ (src >> 5)) + ((src << 4) ^ (src >> 3)));
  assign mix_var = (src + SUM_VAR) ^ (cfg.key[KA] + (src >> 5)) ^
                   (cfg.key[KB] + (src << 4));
  assign dst_nxt = dst - (cfg.variant ? mix_var : mix_std);

  always_comb begin
    word_nxt = pipe_in.w;
    if (pipe_in.w.full) begin
      if (UPD_X) begin
        word_nxt.x = dst_nxt;
      end else begin
        word_nxt.y = dst_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (en) begin
      valid_r <= pipe_in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      word_r <= word_nxt;
    end
  end

  assign pipe_out.valid = valid_r;
  assign pipe_out.w     = word_r;

endmodule

`default_nettype wire

>>> design/tvbd_skid.sv
// ---------------------------------------------------------------------------
// tvbd_skid: output register with skid entry
// Presents results on the output channel and parks one extra result when
// the consumer stalls, so the pipeline enable is a registered signal.
// ---------------------------------------------------------------------------
`default_nettype none

module tvbd_skid (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire tvbd_pkg::tvbd_pipe_t pipe_in,
  input  wire logic                 out_ready,
  output      logic                 pipe_en,
  output      logic                 out_valid,
  output      logic [63:0]          out_data,
  output      logic [3:0]           out_count
);

  logic        out_valid_r;
  logic        out_valid_nxt;
  logic        skid_valid_r;
  logic        skid_valid_nxt;
  logic [67:0] out_r;
  logic [67:0] out_nxt;
  logic [67:0] skid_r;
  logic [67:0] skid_nxt;
  logic [67:0] push_data;
  logic        push;
  logic        drain;

  assign pipe_en   = ~skid_valid_r;
  assign push      = pipe_en & pipe_in.valid;
  assign push_data = {pipe_in.w.count, pipe_in.w.y, pipe_in.w.x};
  assign drain     = ~out_valid_r | out_ready;

  // Output slot refills from the skid entry first, then from the pipeline.
  always_comb begin
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    if (drain) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        out_valid_nxt  = 1'b1;
        skid_valid_nxt = 1'b0;
      end else begin
        out_nxt       = push_data;
        out_valid_nxt = push;
      end
    end else if (push) begin
      skid_nxt       = push_data;
      skid_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r[63:0];
  assign out_count = out_r[67:64];

endmodule

`default_nettype wire

>>> design/tea_variant_block_decrypt.sv
// ---------------------------------------------------------------------------
// tea_variant_block_decrypt: pipelined TEA-variant block decryptor
// Decrypts full 8-byte blocks through one registered half round per stage
// and applies the keyed tail XOR to partial final items.
// ---------------------------------------------------------------------------
// Stages: one capture stage, two half-round stages per round, one output register.
// Throughput: one request per cycle while the skid entry is empty; the pipeline
//   moves as one unit and a skid entry at the output absorbs a consumer stall.
// Reset: synchronous, active low; clears all valid bits and the configuration registers.
`default_nettype none

module tea_variant_block_decrypt #(
  parameter int ROUNDS = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  tvbd_in_if.sink          in_chan,
  tvbd_out_if.source       out_chan,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready
);

  localparam int NSTAGE = 2 * ROUNDS;

  tvbd_pkg::tvbd_cfg_t  cfg;
  tvbd_pkg::tvbd_pipe_t pipe [NSTAGE + 1];
  logic                 pipe_en;

  // Configuration registers.
  tvbd_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // Request capture and tail handling.
  assign in_chan.ready = pipe_en;

  tvbd_tail u_tail (
    .clk        (clk),
    .rst_n      (rst_n),
    .en         (pipe_en),
    .in_valid   (in_chan.valid),
    .block_data (in_chan.block_data),
    .byte_count (in_chan.byte_count),
    .cfg        (cfg),
    .pipe_out   (pipe[0])
  );

  // Half-round stages: even stages update y, odd stages update x.
  for (genvar h = 0; h < NSTAGE; h++) begin : g_stage
    localparam int          RND   = h / 2;
    localparam bit          UPD   = (h % 2) == 1;
    localparam logic [31:0] S_STD = tvbd_pkg::sum_at(RND);
    localparam logic [31:0] S_VAR = UPD ? tvbd_pkg::sum_at(RND + 1)
                                        : tvbd_pkg::sum_at(RND);

    tvbd_stage #(
      .SUM_STD (S_STD),
      .SUM_VAR (S_VAR),
      .UPD_X   (UPD)
    ) u_stage (
      .clk      (clk),
      .rst_n    (rst_n),
      .en       (pipe_en),
      .cfg      (cfg),
      .pipe_in  (pipe[h]),
      .pipe_out (pipe[h + 1])
    );
  end

  // Output register and skid entry.
  tvbd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .pipe_in   (pipe[NSTAGE]),
    .out_ready (out_chan.ready),
    .pipe_en   (pipe_en),
    .out_valid (out_chan.valid),
    .out_data  (out_chan.plain_data),
    .out_count (out_chan.plain_count)
  );

  // The skid entry fills only when a shown result was held back.
  a_skid_fill: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(pipe_en) |-> $past(out_chan.valid && !out_chan.ready))
    else $error("skid entry filled without an output stall");

  // While the skid entry holds a result, the output slot is occupied.
  a_skid_order: assert property (@(posedge clk) disable iff (!rst_n)
    !pipe_en |-> out_chan.valid)
    else $error("skid entry holds a result behind an empty output slot");

  // Bytes at or beyond a short count are zero.
  a_tail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_chan.valid && out_chan.plain_count < 4'd8) |->
      ((out_chan.plain_data >> {out_chan.plain_count, 3'b000}) == 64'd0))
    else $error("result bytes beyond the count are not zero");

endmodule

`default_nettype wire
